>>> rtl/core/pbwl_pkg.sv
// pbwl_pkg: shared widths, codes and helpers of the port bandwidth watermark limiter
// no dependencies; imported by the interfaces, the divider and the top level
package pbwl_pkg;

    localparam int NUM_PORTS  = 8;
    localparam int NUM_SLOTS  = 2 * NUM_PORTS;
    localparam int SLOT_W     = $clog2(NUM_SLOTS);

    localparam int PORT_W     = 3;
    localparam int NOW_W      = 48;
    localparam int SIZE_W     = 32;
    localparam int BPC_W      = 16;
    localparam int LAT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_STEPS  = SIZE_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int DUR_W      = SIZE_W + 1;

    typedef logic [NOW_W-1:0] t_cycle;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTES_PER_CYCLE   = 2'd0,
        CFG_BASE_LATENCY      = 2'd1,
        CFG_SHARED_READ_WRITE = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_QUERY  = 1'b0,
        OP_COMMIT = 1'b1
    } t_op;

    localparam t_cycle CYCLE_MAX = '1;

    function automatic t_cycle sat_add(input t_cycle a, input logic [DUR_W-1:0] b);
        logic [NOW_W:0] s;
        begin
            s = {1'b0, a} + (NOW_W + 1)'(b);
            sat_add = s[NOW_W] ? CYCLE_MAX : s[NOW_W-1:0];
        end
    endfunction

endpackage

>>> rtl/core/pbwl_if.sv
// pbwl_if: valid/ready channels of the limiter (request, result, register write)
// depends on pbwl_pkg for field widths
interface pbwl_req_if import pbwl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [PORT_W-1:0] port_index;
    logic [NOW_W-1:0]  now;
    logic [SIZE_W-1:0] transfer_size;
    logic              write_dir;

    modport source (output valid, op, port_index, now, transfer_size, write_dir,
                    input ready);
    modport sink   (input valid, op, port_index, now, transfer_size, write_dir,
                    output ready);
endinterface

interface pbwl_rsp_if import pbwl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [NOW_W-1:0] delay_cycles;

    modport source (output valid, delay_cycles, input ready);
    modport sink   (input valid, delay_cycles, output ready);
endinterface

interface pbwl_cfg_if import pbwl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/pbwl_ram.sv
// pbwl_ram: generic single write port, single read port ram with registered read
// no dependencies
module pbwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/pbwl_div.sv
// pbwl_div: radix-2 restoring divider giving ceil(dividend / divisor), one bit a cycle
// depends on pbwl_pkg; divisor must be nonzero while busy
module pbwl_div import pbwl_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SIZE_W-1:0] i_dividend,
    input  logic [BPC_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [DUR_W-1:0]  o_ceil
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [BPC_W-1:0]     r_rem;
    logic [SIZE_W-1:0]    r_quo;
    logic [BPC_W-1:0]     r_div;

    logic [BPC_W:0]       trial;
    logic                 fits;
    logic [BPC_W-1:0]     n_rem;

    always_comb begin
        trial = {r_rem, r_quo[SIZE_W-1]};
        fits  = trial >= {1'b0, r_div};
        n_rem = fits ? BPC_W'(trial - {1'b0, r_div}) : trial[BPC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[SIZE_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_ceil = {1'b0, r_quo} + DUR_W'(|r_rem);

endmodule

>>> rtl/core/port_bandwidth_watermark_limiter_top.sv
// port_bandwidth_watermark_limiter_top: per-port read/write watermark bandwidth limiter
// depends on pbwl_pkg, pbwl_if (request, result and register channels), pbwl_ram, pbwl_div
//
// usage:
//   i_cfg writes bytes_per_cycle (index 0), base_latency (1), shared_read_write (2);
//   it is always ready and should be written only while no request is in flight
//   i_req takes one word at a time: a query returns max(watermark - now, 0) plus
//   base_latency; a commit to an active port books ceil(transfer_size /
//   bytes_per_cycle) cycles after max(now, watermark); every commit returns 0
//   o_rsp gives exactly one word per request
// timing:
//   a query result is registered after S_LOOK (ram read out, compare) and S_FIN (add)
//   a commit to an active port also waits in S_DIV for the 32-step divider;
//   a commit to an unlimited or out-of-range port goes through S_LOOK and S_FIN only
//   a new request is accepted at the earliest the cycle after the previous result is
//   registered, so the limiter never takes a request before the last one is through
// reset:
//   synchronous reset clears control registers and all 16 watermark valid bits at once;
//   an entry never written reads as zero, so no clearing pass is needed
// stall:
//   a finished result waits in the output register; while it is not taken the
//   next request still runs up to its own result and then holds
module port_bandwidth_watermark_limiter_top import pbwl_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pbwl_req_if.sink   i_req,
    pbwl_rsp_if.source o_rsp,
    pbwl_cfg_if.sink   i_cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_DIV,
        S_FIN
    } t_state;

    t_state            r_state;
    logic [BPC_W-1:0]  r_bpc;
    logic [LAT_W-1:0]  r_lat;
    logic              r_shared;
    logic [NUM_SLOTS-1:0] r_vld;

    logic              r_op;
    logic              r_active;
    logic [SLOT_W-1:0] r_slot;
    t_cycle            r_now;
    t_cycle            r_wait;
    t_cycle            r_start;
    logic [DUR_W-1:0]  r_dur;

    logic              r_out_valid;
    t_cycle            r_out_data;

    logic              req_fire;
    logic              sel_wr;
    logic [PORT_W:0]   slot_wide;
    logic [SLOT_W-1:0] n_slot;
    logic              n_active;
    logic              div_start;
    logic              div_done;
    logic [DUR_W-1:0]  div_ceil;
    t_cycle            ram_rdata;
    t_cycle            wm;
    logic              ram_we;
    logic              out_free;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;

    always_comb begin
        sel_wr    = i_req.write_dir || r_shared;
        slot_wide = {i_req.port_index, sel_wr};
        n_slot    = SLOT_W'(slot_wide);
        n_active  = (r_bpc != '0) && (7'(i_req.port_index) < 7'(NUM_PORTS));
        div_start = req_fire && (i_req.op == OP_COMMIT) && n_active;
        wm        = (r_active && r_vld[r_slot]) ? ram_rdata : '0;
        out_free  = !r_out_valid || o_rsp.ready;
        ram_we    = (r_state == S_FIN) && out_free && (r_op == OP_COMMIT) && r_active;
    end

    pbwl_ram #(
        .WIDTH (NOW_W),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (sat_add(r_start, r_dur)),
        .i_raddr (n_slot),
        .o_rdata (ram_rdata)
    );

    pbwl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_req.transfer_size),
        .i_divisor  (r_bpc),
        .o_done     (div_done),
        .o_ceil     (div_ceil)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpc    <= '0;
            r_lat    <= '0;
            r_shared <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_BYTES_PER_CYCLE:   r_bpc    <= i_cfg.data[BPC_W-1:0];
                CFG_BASE_LATENCY:      r_lat    <= i_cfg.data[LAT_W-1:0];
                CFG_SHARED_READ_WRITE: r_shared <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= (r_op == OP_COMMIT && r_active) ? S_DIV : S_FIN;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        if (ram_we) begin
                            r_vld[r_slot] <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_op     <= i_req.op;
            r_active <= n_active;
            r_slot   <= n_slot;
            r_now    <= i_req.now;
        end
        if (r_state == S_LOOK) begin
            r_wait  <= (wm > r_now) ? wm - r_now : '0;
            r_start <= (wm > r_now) ? wm : r_now;
        end
        if (r_state == S_DIV && div_done) begin
            r_dur <= div_ceil;
        end
        if (r_state == S_FIN && out_free) begin
            r_out_data <= (r_op == OP_COMMIT) ? '0 : sat_add(r_wait, DUR_W'(r_lat));
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.delay_cycles = r_out_data;

endmodule
